@@ hw/rtl/sbrp_pkg.sv @@
// Shared types and constants for the STUN binding response parser.
// No dependencies; imported by sbrp_core and stun_binding_response_parser.
package sbrp_pkg;

  // Bytes beyond this position within a datagram are not parsed.
  localparam int MAX_DATAGRAM_BYTES = 1024;
  localparam int POS_W = $clog2(MAX_DATAGRAM_BYTES + 1);

  // Body offsets need one bit beyond the 16-bit length field.
  localparam int OFF_W = 17;

  // Message and attribute constants.
  localparam logic [15:0] TYPE_SUCCESS    = 16'h0101;
  localparam logic [31:0] MAGIC_COOKIE    = 32'h2112_A442;
  localparam logic [15:0] ATTR_MAPPED     = 16'h0001;
  localparam logic [15:0] ATTR_XOR_MAPPED = 16'h0020;
  localparam logic [7:0]  FAMILY_V4       = 8'h01;

  // Configuration register indexes.
  localparam logic CFG_TXID_UPPER = 1'b0;
  localparam logic CFG_TXID_LOWER = 1'b1;

  // One parse result, produced with the final byte of a datagram.
  typedef struct packed {
    logic        found;
    logic [15:0] port;
    logic [31:0] address;
  } sbrp_result_t;

endpackage

@@ hw/rtl/stun_binding_response_parser.sv @@
// Latency: the result is valid in the cycle after the final byte is accepted.
// Throughput: one datagram byte per cycle; a byte is taken while a result waits
// unless the result register is full and not being drained this cycle.
// Reset (rst_n low, synchronous) clears the parse state, the result valid flag
// and both transaction ID registers. Depends on sbrp_pkg and sbrp_core.
module stun_binding_response_parser (
  input  logic        clk,
  input  logic        rst_n,
  // Datagram byte stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  // Parse results.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] public_port, [47:16] mapped IPv4 address
  output logic        out_tuser,  // found
  // Configuration writes.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata
);
  import sbrp_pkg::*;

  logic [31:0]  txid_upper_r;
  logic [63:0]  txid_lower_r;
  logic         out_valid_r;
  sbrp_result_t out_res_r;
  sbrp_result_t step_res;
  logic         in_take;

  // Accept a byte whenever the result register is empty or draining.
  assign in_tready = !out_valid_r || out_tready;
  assign in_take   = in_tvalid && in_tready;

  sbrp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (in_take),
    .data_byte  (in_tdata),
    .last_byte  (in_tlast),
    .txid_upper (txid_upper_r),
    .txid_lower (txid_lower_r),
    .result     (step_res)
  );

  // Transaction ID registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      txid_upper_r <= '0;
      txid_lower_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TXID_UPPER: txid_upper_r <= cfg_wdata[31:0];
        CFG_TXID_LOWER: txid_lower_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Result register, loaded with the final byte of each datagram.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take && in_tlast) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_tlast) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.found;
  assign out_tdata  = {out_res_r.address, out_res_r.port};

endmodule

@@ hw/rtl/sbrp_core.sv @@
// Per-byte parse state and next-state logic for the STUN binding response parser.
// Depends on sbrp_pkg for constants and the result struct.
module sbrp_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  input  logic [31:0]           txid_upper,
  input  logic [63:0]           txid_lower,
  output sbrp_pkg::sbrp_result_t result
);
  import sbrp_pkg::*;

  typedef enum logic [1:0] {ST_RUNNING, ST_FAILED, ST_MATCHED} status_t;

  // Header length, header byte positions where a field completes, and the parse cap.
  localparam logic [POS_W-1:0] HDR_BYTES  = POS_W'(20);
  localparam logic [POS_W-1:0] POS_TYPE   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LENGTH = POS_W'(3);
  localparam logic [POS_W-1:0] POS_COOKIE = POS_W'(7);
  localparam logic [POS_W-1:0] POS_TXID0  = POS_W'(11);
  localparam logic [POS_W-1:0] POS_TXID1  = POS_W'(15);
  localparam logic [POS_W-1:0] POS_TXID2  = POS_W'(19);
  localparam logic [POS_W-1:0] POS_CAP    = POS_W'(MAX_DATAGRAM_BYTES);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      hdr_r, hdr_nxt;
  logic [15:0]      decl_len_r, decl_len_nxt;
  logic [OFF_W-1:0] attr_off_r, attr_off_nxt;
  logic [15:0]      attr_type_r, attr_type_nxt;
  logic [15:0]      attr_len_r, attr_len_nxt;
  logic [63:0]      window_r, window_nxt;
  status_t          status_r, status_nxt;
  logic [15:0]      port_r, port_nxt;
  logic [31:0]      addr_r, addr_nxt;

  logic [31:0]      shifted;
  logic [OFF_W-1:0] body;
  logic [OFF_W-1:0] rel;
  logic [OFF_W-1:0] val_idx;
  logic             in_padding;
  logic             attr_hdr_done;
  logic             do_finish;

  // Inputs of the attribute-finish logic.
  logic [15:0]      f_type;
  logic [15:0]      f_len;
  logic [63:0]      f_win;
  logic             f_is_xor;
  logic             f_match;
  logic [OFF_W-1:0] f_len_pad;
  logic [OFF_W:0]   f_next_off;
  logic [OFF_W:0]   overrun_end;

  // Position bookkeeping for the body walk.
  always_comb begin
    shifted     = {hdr_r[23:0], data_byte};
    body        = OFF_W'(pos_r - HDR_BYTES);
    in_padding  = body < attr_off_r;
    rel         = body - attr_off_r;
    val_idx     = rel - OFF_W'(4);
    overrun_end = {1'b0, attr_off_r} + (OFF_W + 1)'(4) + (OFF_W + 1)'(shifted[15:0]);
  end

  // Attribute-finish logic, fed either by a fresh zero-length header or the registers.
  // The value window includes the byte arriving now.
  always_comb begin
    attr_hdr_done = (pos_r >= HDR_BYTES) && !in_padding && (rel == OFF_W'(3));
    if (attr_hdr_done) begin
      f_type = shifted[31:16];
      f_len  = shifted[15:0];
      f_win  = '0;
    end else begin
      f_type = attr_type_r;
      f_len  = attr_len_r;
      f_win  = (val_idx < OFF_W'(8)) ? {window_r[55:0], data_byte} : window_r;
    end
    f_is_xor   = f_type == ATTR_XOR_MAPPED;
    f_match    = (f_is_xor || (f_type == ATTR_MAPPED)) && (f_len >= 16'd8) &&
                 (f_win[55:48] == FAMILY_V4);
    f_len_pad  = ({1'b0, f_len} + OFF_W'(3)) & ~OFF_W'(3);
    f_next_off = {1'b0, attr_off_r} + (OFF_W + 1)'(4) + {1'b0, f_len_pad};
  end

  // Next-state logic for one accepted byte.
  always_comb begin
    pos_nxt       = pos_r;
    hdr_nxt       = hdr_r;
    decl_len_nxt  = decl_len_r;
    attr_off_nxt  = attr_off_r;
    attr_type_nxt = attr_type_r;
    attr_len_nxt  = attr_len_r;
    window_nxt    = window_r;
    status_nxt    = status_r;
    port_nxt      = port_r;
    addr_nxt      = addr_r;
    do_finish     = 1'b0;

    if (pos_r != POS_CAP) begin
      pos_nxt = pos_r + POS_W'(1);
      if (status_r == ST_RUNNING) begin
        if (pos_r < HDR_BYTES) begin
          // Fixed header: type, length, cookie and transaction ID.
          hdr_nxt = shifted;
          case (pos_r)
            POS_TYPE:   if (shifted[15:0] != TYPE_SUCCESS) status_nxt = ST_FAILED;
            POS_LENGTH: decl_len_nxt = shifted[15:0];
            POS_COOKIE: if (shifted != MAGIC_COOKIE) status_nxt = ST_FAILED;
            POS_TXID0:  if (shifted != txid_upper) status_nxt = ST_FAILED;
            POS_TXID1:  if (shifted != txid_lower[63:32]) status_nxt = ST_FAILED;
            POS_TXID2: begin
              if (shifted != txid_lower[31:0]) begin
                status_nxt = ST_FAILED;
              end else if (decl_len_r < 16'd4) begin
                status_nxt = ST_FAILED;
              end
            end
            default: ;
          endcase
        end else if (!in_padding) begin
          if (rel < OFF_W'(4)) begin
            // Attribute header: type then length.
            hdr_nxt = shifted;
            if (attr_hdr_done) begin
              attr_type_nxt = shifted[31:16];
              attr_len_nxt  = shifted[15:0];
              window_nxt    = '0;
              if (overrun_end > (OFF_W + 1)'(decl_len_r)) begin
                status_nxt = ST_FAILED;
              end else if (shifted[15:0] == 16'd0) begin
                do_finish = 1'b1;
              end
            end
          end else begin
            // Attribute value: keep the first eight bytes.
            if (val_idx < OFF_W'(8)) window_nxt = {window_r[55:0], data_byte};
            if ((val_idx + OFF_W'(1)) == OFF_W'(attr_len_r)) do_finish = 1'b1;
          end
        end
      end
    end

    // Close the current attribute: latch a match or step to the next one.
    if (do_finish) begin
      if (f_match) begin
        port_nxt   = f_win[47:32] ^ (f_is_xor ? MAGIC_COOKIE[31:16] : 16'h0000);
        addr_nxt   = f_win[31:0] ^ (f_is_xor ? MAGIC_COOKIE : 32'h0000_0000);
        status_nxt = ST_MATCHED;
      end else begin
        attr_off_nxt = f_next_off[OFF_W-1:0];
        if ((f_next_off + (OFF_W + 1)'(4)) > (OFF_W + 1)'(decl_len_r)) begin
          status_nxt = ST_FAILED;
        end
      end
    end
  end

  // Result seen after this byte; meaningful with the final byte.
  always_comb begin
    result.found   = status_nxt == ST_MATCHED;
    result.port    = result.found ? port_nxt : 16'h0000;
    result.address = result.found ? addr_nxt : 32'h0000_0000;
  end

  // State registers; the final byte of a datagram returns them to reset.
  always_ff @(posedge clk) begin
    if (!rst_n || (take && last_byte)) begin
      pos_r       <= '0;
      hdr_r       <= '0;
      decl_len_r  <= '0;
      attr_off_r  <= '0;
      attr_type_r <= '0;
      attr_len_r  <= '0;
      window_r    <= '0;
      status_r    <= ST_RUNNING;
      port_r      <= '0;
      addr_r      <= '0;
    end else if (take) begin
      pos_r       <= pos_nxt;
      hdr_r       <= hdr_nxt;
      decl_len_r  <= decl_len_nxt;
      attr_off_r  <= attr_off_nxt;
      attr_type_r <= attr_type_nxt;
      attr_len_r  <= attr_len_nxt;
      window_r    <= window_nxt;
      status_r    <= status_nxt;
      port_r      <= port_nxt;
      addr_r      <= addr_nxt;
    end
  end

endmodule
